// ----- sv/mie_pkg.sv -----
// ----------------------------------------------------------------------------
// mie_pkg
// Shared constants and types for the modular inverse block.
// ----------------------------------------------------------------------------
package mie_pkg;

    localparam int WIDTH = 32;
    localparam int KW    = $clog2(WIDTH);

    localparam logic [KW-1:0] KMAX = KW'(WIDTH - 1);

    // sequencer state codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ALIGN = 3'd1;
    localparam logic [2:0] ST_SUB   = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;

    typedef struct packed {
        logic [WIDTH-1:0] divisor;
        logic [WIDTH-1:0] num;
        logic [WIDTH-1:0] coef;
        logic [WIDTH-1:0] acc;
        logic [KW-1:0]    shamt;
    } t_div_in;

    typedef struct packed {
        logic             fit_next;
        logic             fit;
        logic [WIDTH-1:0] num_sub;
        logic [WIDTH-1:0] acc_add;
    } t_div_out;

endpackage

// ----- sv/mie_div_step.sv -----
// ----------------------------------------------------------------------------
// mie_div_step
// Shared shift / compare / subtract unit: one quotient bit per use, with the
// Bezout coefficient accumulated alongside the quotient.
// ----------------------------------------------------------------------------
module mie_div_step (
    input  mie_pkg::t_div_in  i_op,
    output mie_pkg::t_div_out o_res
);

    logic [2*mie_pkg::WIDTH-1:0] dw0;
    logic [2*mie_pkg::WIDTH-1:0] dw1;
    logic [2*mie_pkg::WIDTH-1:0] numw;
    logic [mie_pkg::WIDTH-1:0]   coef_sh;

    assign numw    = {{mie_pkg::WIDTH{1'b0}}, i_op.num};
    assign dw0     = {{mie_pkg::WIDTH{1'b0}}, i_op.divisor} << i_op.shamt;
    assign dw1     = dw0 << 1;
    assign coef_sh = i_op.coef << i_op.shamt;

    assign o_res.fit      = (dw0 <= numw);
    assign o_res.fit_next = (i_op.shamt != mie_pkg::KMAX) && (dw1 <= numw);
    assign o_res.num_sub  = i_op.num - dw0[mie_pkg::WIDTH-1:0];
    assign o_res.acc_add  = i_op.acc + coef_sh;

endmodule

// ----- sv/mod_inverse_extended_euclid_top.sv -----
// ----------------------------------------------------------------------------
// mod_inverse_extended_euclid_top
// Modular inverse by the extended Euclidean algorithm on one shared
// shift-subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  word fields (low bit up)
//  s_axis    in   tdata: value[31:0], modulus[63:32]
//  m_axis    out  tdata: inverse[31:0]; tuser: found
//
//  The value is first reduced mod the modulus, then each Euclid step divides
//  bit by bit (at least one quotient bit per step): align the divisor, then
//  subtract it shift by shift; steps repeat until a remainder is zero, then
//  the result is finished. A modulus of zero goes from accept straight to
//  finish. Input is taken only when idle.
//  Result word waits in an output register; a stalled output holds the
//  finish state. Reset (i_rst_n low, synchronous) returns to idle.
// ----------------------------------------------------------------------------
module mod_inverse_extended_euclid_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // value[31:0], modulus[63:32]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // inverse[31:0]
    output logic        o_m_axis_tuser    // found
);

    localparam int W = mie_pkg::WIDTH;

    logic [2:0]   r_state;
    logic [W-1:0] r_m, r_r0, r_r1, r_num, r_c0, r_c1, r_acc;
    logic         r_neg0, r_neg1, r_red;
    logic [mie_pkg::KW-1:0] r_k;
    logic         r_ovalid;
    logic [W-1:0] r_inv;
    logic         r_found;

    mie_pkg::t_div_in  div_in;
    mie_pkg::t_div_out div_out;

    logic         in_acc, out_free;
    logic [W-1:0] n_num, n_acc, n_r0, n_r1, c0m, fin_inv;
    logic         fin_found;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ovalid || i_m_axis_tready;

    assign div_in.divisor = r_red ? r_r0 : r_r1;
    assign div_in.num     = r_num;
    assign div_in.coef    = r_c1;
    assign div_in.acc     = r_acc;
    assign div_in.shamt   = r_k;

    mie_div_step u_step (
        .i_op  (div_in),
        .o_res (div_out)
    );

    assign n_num = div_out.fit ? div_out.num_sub : r_num;
    assign n_acc = div_out.fit ? div_out.acc_add : r_acc;
    assign n_r0  = r_red ? r_r0 : r_r1;
    assign n_r1  = n_num;

    assign fin_found = (r_r0 == W'(1));
    assign c0m       = (r_c0 >= r_m) ? (r_c0 - r_m) : r_c0;
    assign fin_inv   = !fin_found ? '0 :
                       (r_neg0 && c0m != '0) ? (r_m - c0m) : c0m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mie_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_axis_tready && r_state != mie_pkg::ST_FIN) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                mie_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        r_m    <= i_s_axis_tdata[63:32];
                        r_r0   <= i_s_axis_tdata[63:32];
                        r_num  <= i_s_axis_tdata[31:0];
                        r_c0   <= '0;
                        r_c1   <= W'(1);
                        r_acc  <= '0;
                        r_neg0 <= 1'b0;
                        r_neg1 <= 1'b0;
                        r_red  <= 1'b1;
                        r_k    <= '0;
                        r_state <= (i_s_axis_tdata[63:32] == '0) ? mie_pkg::ST_FIN
                                                                 : mie_pkg::ST_ALIGN;
                    end
                end
                mie_pkg::ST_ALIGN: begin
                    if (div_out.fit_next) begin
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_state <= mie_pkg::ST_SUB;
                    end
                end
                mie_pkg::ST_SUB: begin
                    if (r_k != '0) begin
                        r_num <= n_num;
                        r_acc <= n_acc;
                        r_k   <= r_k - 1'b1;
                    end else begin
                        // quotient done: rotate the Euclid registers
                        r_red <= 1'b0;
                        r_r0  <= n_r0;
                        r_r1  <= n_r1;
                        r_num <= n_r0;
                        if (!r_red) begin
                            r_c0   <= r_c1;
                            r_c1   <= n_acc;
                            r_acc  <= r_c1;
                            r_neg0 <= r_neg1;
                            r_neg1 <= !r_neg1;
                        end else begin
                            r_acc <= r_c0;
                        end
                        r_state <= (n_r1 == '0) ? mie_pkg::ST_FIN : mie_pkg::ST_ALIGN;
                    end
                end
                mie_pkg::ST_FIN: begin
                    if (out_free) begin
                        r_inv    <= fin_inv;
                        r_found  <= fin_found;
                        r_ovalid <= 1'b1;
                        r_state  <= mie_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= mie_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == mie_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_inv;
    assign o_m_axis_tuser  = r_found;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_axis_tready)
        else $error("input accepted but block still idle");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mie_pkg::ST_ALIGN || r_state == mie_pkg::ST_SUB) |->
        div_in.divisor != '0)
        else $error("divide step with zero divisor");

    a_coef_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mie_pkg::ST_FIN && r_m != '0) |-> (r_c0 <= r_m))
        else $error("Bezout coefficient exceeds modulus");

    a_nofound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_found) |-> (r_inv == '0))
        else $error("nonzero inverse without found flag");
`endif

endmodule
